// ===== sv/tmfa_pkg.sv =====
package tmfa_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic signed [31:0] COEF_A = 32'sd1852966853;
	localparam logic signed [31:0] COEF_B = -32'sd811692739;
	localparam logic signed [31:0] COEF_C = 32'sd32467710;
	localparam logic signed [63:0] FILT_ROUND = 64'sd536870912;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	localparam logic [1:0] REG_RPM_SCALE     = 2'd0;
	localparam logic [1:0] REG_JAM_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_JAM_TICKS     = 2'd2;
	localparam logic [1:0] REG_REVERSE_TICKS = 2'd3;

	typedef struct packed {
		logic [23:0] rpm_scale;
		logic [30:0] jam_speed_threshold;
		logic [15:0] jam_ticks;
		logic [15:0] reverse_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_DEC,
		STEP_INC
	} step_t;

	typedef struct packed {
		logic signed [31:0] x;
		step_t              step;
		logic [12:0]        encoder_now;
		logic signed [31:0] target_speed;
		logic               antijam_enable;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL_A,
		B_MUL_B,
		B_MUL_C,
		B_FINISH,
		B_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		MSEL_A,
		MSEL_B,
		MSEL_C
	} mul_sel_t;

	typedef struct packed {
		logic     pop;
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     acc_init;
		logic     acc_add;
		logic     finish;
		logic     emit;
	} back_ctrl_t;

endpackage

// ===== sv/trigger_motor_feedback_antijam_top.sv =====
// channel   direction  handshake             payload
// in        to block   in_valid / in_stall   encoder_now, encoder_before, motor_rpm,
//                                            target_speed, antijam_enable
// out       from block out_valid / out_stall filtered_speed, turn_count,
//                                            multiturn_position, speed_command, reversing
// cfg       to block   cfg_we                cfg_index, cfg_data
//
// An item passes the front stage register, then the back sequencer, which takes it from the
// queue, forms three products on the shared 32x32 multiplier, sums and saturates, and loads
// the output register. The sequencer takes a new item only after loading the last result.
// Reset loads the register defaults and clears filter, turn and jam state.
// A stalled output holds the back sequencer; the two-entry queue and the front stage keep
// taking items until both are full.
module trigger_motor_feedback_antijam_top #(
	parameter int ENCODER_RANGE = 8191,
	parameter int TURN_LIMIT    = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [12:0]        encoder_now,
	input  logic [12:0]        encoder_before,
	input  logic signed [15:0] motor_rpm,
	input  logic signed [31:0] target_speed,
	input  logic               antijam_enable,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] filtered_speed,
	output logic signed [5:0]  turn_count,
	output logic signed [18:0] multiturn_position,
	output logic signed [31:0] speed_command,
	output logic               reversing
);
	import tmfa_pkg::*;

	cfg_t cfg_q;
	logic push;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop;
	job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_scale           <= 24'd48803;
			cfg_q.jam_speed_threshold <= 31'd65536;
			cfg_q.jam_ticks           <= 16'd700;
			cfg_q.reverse_ticks       <= 16'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RPM_SCALE:     cfg_q.rpm_scale           <= cfg_data[23:0];
				REG_JAM_THRESHOLD: cfg_q.jam_speed_threshold <= cfg_data;
				REG_JAM_TICKS:     cfg_q.jam_ticks           <= cfg_data[15:0];
				REG_REVERSE_TICKS: cfg_q.reverse_ticks       <= cfg_data[15:0];
				default:           cfg_q                     <= cfg_q;
			endcase
		end
	end

	tmfa_front #(
		.ENCODER_RANGE(ENCODER_RANGE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.encoder_now   (encoder_now),
		.encoder_before(encoder_before),
		.motor_rpm     (motor_rpm),
		.target_speed  (target_speed),
		.antijam_enable(antijam_enable),
		.rpm_scale     (cfg_q.rpm_scale),
		.push          (push),
		.push_ready    (push_ready),
		.push_job      (push_job)
	);

	tmfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job)
	);

	tmfa_back #(
		.ENCODER_RANGE(ENCODER_RANGE),
		.TURN_LIMIT   (TURN_LIMIT)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.pop_valid         (pop_valid),
		.pop               (pop),
		.pop_job           (pop_job),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_speed    (filtered_speed),
		.turn_count        (turn_count),
		.multiturn_position(multiturn_position),
		.speed_command     (speed_command),
		.reversing         (reversing)
	);

endmodule

// ===== sv/tmfa_front.sv =====
module tmfa_front #(
	parameter int ENCODER_RANGE = 8191
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [12:0]         encoder_now,
	input  logic [12:0]         encoder_before,
	input  logic signed [15:0]  motor_rpm,
	input  logic signed [31:0]  target_speed,
	input  logic                antijam_enable,
	input  logic [23:0]         rpm_scale,
	output logic                push,
	input  logic                push_ready,
	output tmfa_pkg::job_t      push_job
);
	import tmfa_pkg::*;

	localparam int HALF_I = (ENCODER_RANGE + 1) / 2;
	localparam logic signed [17:0] HALF_P = 18'(HALF_I);
	localparam logic signed [17:0] HALF_N = -HALF_P;
	localparam logic signed [40:0] X_MAX = 41'sh00_7FFF_FFFF;
	localparam logic signed [40:0] X_MIN = -41'sh00_8000_0000;

	logic               valid_q;
	logic [12:0]        now_q;
	logic [12:0]        before_q;
	logic signed [15:0] rpm_q;
	logic signed [31:0] target_q;
	logic               enable_q;

	logic signed [40:0] prod;
	logic signed [40:0] shifted;
	logic signed [17:0] diff;
	logic               accept;

	assign in_stall = valid_q && !push_ready;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_q && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= encoder_now;
			before_q <= encoder_before;
			rpm_q    <= motor_rpm;
			target_q <= target_speed;
			enable_q <= antijam_enable;
		end
	end

	always_comb begin
		prod    = 41'(rpm_q) * 41'($signed({1'b0, rpm_scale}));
		shifted = (prod + 41'sd128) >>> 8;
		diff    = $signed({5'b0, now_q}) - $signed({5'b0, before_q});

		push_job.encoder_now    = now_q;
		push_job.target_speed   = target_q;
		push_job.antijam_enable = enable_q;

		if (shifted > X_MAX) begin
			push_job.x = S32_MAX;
		end else if (shifted < X_MIN) begin
			push_job.x = S32_MIN;
		end else begin
			push_job.x = shifted[31:0];
		end

		if (diff > HALF_P) begin
			push_job.step = STEP_DEC;
		end else if (diff < HALF_N) begin
			push_job.step = STEP_INC;
		end else begin
			push_job.step = STEP_NONE;
		end
	end

endmodule

// ===== sv/tmfa_queue.sv =====
module tmfa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  tmfa_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop,
	output tmfa_pkg::job_t pop_job
);
	import tmfa_pkg::*;

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/tmfa_back.sv =====
module tmfa_back #(
	parameter int ENCODER_RANGE = 8191,
	parameter int TURN_LIMIT    = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmfa_pkg::cfg_t     cfg,
	input  logic               pop_valid,
	output logic               pop,
	input  tmfa_pkg::job_t     pop_job,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] filtered_speed,
	output logic signed [5:0]  turn_count,
	output logic signed [18:0] multiturn_position,
	output logic signed [31:0] speed_command,
	output logic               reversing
);
	import tmfa_pkg::*;

	localparam logic signed [5:0]  TL_P   = 6'(TURN_LIMIT);
	localparam logic signed [5:0]  TL_N   = -TL_P;
	localparam logic signed [5:0]  WRAP_P = 6'(TURN_LIMIT - 1);
	localparam logic signed [5:0]  WRAP_N = -WRAP_P;
	localparam logic signed [23:0] RANGE_S = 24'(ENCODER_RANGE);

	back_state_t        state_q;
	back_state_t        state_d;
	back_ctrl_t         ctrl;

	job_t               job_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] older_q;
	logic signed [31:0] newest_q;
	logic signed [5:0]  turns_q;
	logic [15:0]        stall_q;
	logic [15:0]        revc_q;
	logic               out_valid_q;
	logic               out_load;

	logic signed [31:0] coef;
	logic signed [31:0] mul_in;
	logic signed [63:0] sum;
	logic signed [63:0] sum_sh;
	logic signed [31:0] speed_new;
	logic signed [5:0]  turns_step;
	logic signed [5:0]  turns_new;
	logic signed [23:0] pos;
	logic               rev;
	logic signed [31:0] cmd;
	logic [31:0]        mag;
	logic               slow;

	assign out_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign pop       = ctrl.pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (pop_valid) state_d = B_MUL_A;
			B_MUL_A:  state_d = B_MUL_B;
			B_MUL_B:  state_d = B_MUL_C;
			B_MUL_C:  state_d = B_FINISH;
			B_FINISH: state_d = B_EMIT;
			B_EMIT:   if (out_load) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{pop: 1'b0, mul_sel: MSEL_A, mul_en: 1'b0, acc_init: 1'b0,
			acc_add: 1'b0, finish: 1'b0, emit: 1'b0};
		case (state_q)
			B_IDLE: ctrl.pop = pop_valid;
			B_MUL_A: begin
				ctrl.mul_sel = MSEL_A;
				ctrl.mul_en  = 1'b1;
			end
			B_MUL_B: begin
				ctrl.mul_sel  = MSEL_B;
				ctrl.mul_en   = 1'b1;
				ctrl.acc_init = 1'b1;
			end
			B_MUL_C: begin
				ctrl.mul_sel = MSEL_C;
				ctrl.mul_en  = 1'b1;
				ctrl.acc_add = 1'b1;
			end
			B_FINISH: ctrl.finish = 1'b1;
			B_EMIT:   ctrl.emit   = out_load;
			default:  ctrl.pop    = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.mul_sel)
			MSEL_A: begin
				coef   = COEF_A;
				mul_in = newest_q;
			end
			MSEL_B: begin
				coef   = COEF_B;
				mul_in = older_q;
			end
			MSEL_C: begin
				coef   = COEF_C;
				mul_in = job_q.x;
			end
			default: begin
				coef   = COEF_A;
				mul_in = newest_q;
			end
		endcase

		sum    = acc_q + prod_q;
		sum_sh = sum >>> 30;
		if (sum_sh > 64'(S32_MAX)) begin
			speed_new = S32_MAX;
		end else if (sum_sh < 64'(S32_MIN)) begin
			speed_new = S32_MIN;
		end else begin
			speed_new = sum_sh[31:0];
		end

		case (job_q.step)
			STEP_DEC: turns_step = turns_q - 6'sd1;
			STEP_INC: turns_step = turns_q + 6'sd1;
			default:  turns_step = turns_q;
		endcase
		if (turns_step >= TL_P) begin
			turns_new = WRAP_N;
		end else if (turns_step <= TL_N) begin
			turns_new = WRAP_P;
		end else begin
			turns_new = turns_step;
		end

		pos = 24'(turns_q) * RANGE_S + $signed({11'b0, job_q.encoder_now});

		rev = stall_q >= cfg.jam_ticks;
		if (!rev) begin
			cmd = job_q.target_speed;
		end else if (job_q.target_speed == S32_MIN) begin
			cmd = S32_MAX;
		end else begin
			cmd = -job_q.target_speed;
		end
		mag  = newest_q[31] ? 32'(-newest_q) : 32'(newest_q);
		slow = mag < {1'b0, cfg.jam_speed_threshold};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			older_q     <= '0;
			newest_q    <= '0;
			turns_q     <= '0;
			stall_q     <= '0;
			revc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.finish) begin
				older_q  <= newest_q;
				newest_q <= speed_new;
				turns_q  <= turns_new;
			end
			if (ctrl.emit && job_q.antijam_enable) begin
				if (slow && !rev) begin
					stall_q <= stall_q + 16'd1;
					revc_q  <= '0;
				end else if (stall_q == cfg.jam_ticks && revc_q < cfg.reverse_ticks) begin
					revc_q <= revc_q + 16'd1;
				end else begin
					stall_q <= '0;
				end
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			job_q <= pop_job;
		end
		if (ctrl.mul_en) begin
			prod_q <= coef * mul_in;
		end
		if (ctrl.acc_init) begin
			acc_q <= prod_q + FILT_ROUND;
		end else if (ctrl.acc_add) begin
			acc_q <= sum;
		end
		if (ctrl.emit) begin
			filtered_speed     <= newest_q;
			turn_count         <= turns_q;
			multiturn_position <= pos[18:0];
			speed_command      <= job_q.antijam_enable ? cmd : '0;
			reversing          <= job_q.antijam_enable && rev;
		end
	end

endmodule

// ===== sim/trigger_motor_feedback_antijam_checker.sv =====
module trigger_motor_feedback_antijam_checker #(
	parameter int ENCODER_RANGE = 8191,
	parameter int TURN_LIMIT    = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [12:0]        encoder_now,
	input  logic [12:0]        encoder_before,
	input  logic signed [15:0] motor_rpm,
	input  logic signed [31:0] target_speed,
	input  logic               antijam_enable,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] filtered_speed,
	input  logic signed [5:0]  turn_count,
	input  logic signed [18:0] multiturn_position,
	input  logic signed [31:0] speed_command,
	input  logic               reversing,
	output int                 pending,
	output int                 errors,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import tmfa_pkg::*;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [5:0]  turns;
		logic signed [18:0] position;
		logic signed [31:0] command;
		logic               reversed;
	} feedback_t;

	cfg_t               shadow_cfg;
	logic signed [31:0] prior_speed;
	logic signed [31:0] last_speed;
	int                 turn_acc;
	logic [15:0]        stall_ticks;
	logic [15:0]        reverse_done;
	feedback_t          expected_feedback_q[$];

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > longint'(S32_MAX))
			return S32_MAX;
		if (v < longint'(S32_MIN))
			return S32_MIN;
		return v[31:0];
	endfunction

	function automatic longint shaft_scale();
		return longint'(shadow_cfg.rpm_scale);
	endfunction

	function automatic feedback_t compute_feedback(input logic [12:0] now_v,
			input logic [12:0] before_v, input logic signed [15:0] rpm_v,
			input logic signed [31:0] target_v, input logic enable_v);
		feedback_t          r;
		longint             acc;
		longint             diff;
		longint             mag;
		logic signed [31:0] shaft;
		logic signed [31:0] speed;
		int                 pos;

		// scale rpm to shaft speed, then run the recursive low-pass
		acc = (longint'(rpm_v) * longint'(shaft_scale()) + 128) >>> 8;
		shaft = clamp32(acc);
		acc = longint'(COEF_A) * longint'(last_speed) + longint'(COEF_B) * longint'(prior_speed)
			+ longint'(COEF_C) * longint'(shaft) + FILT_ROUND;
		speed = clamp32(acc >>> 30);
		prior_speed = last_speed;
		last_speed = speed;

		diff = longint'(now_v) - longint'(before_v);
		if (diff > (ENCODER_RANGE + 1) / 2)
			turn_acc--;
		else if (diff < -((ENCODER_RANGE + 1) / 2))
			turn_acc++;
		if (turn_acc >= TURN_LIMIT)
			turn_acc = -(TURN_LIMIT - 1);
		else if (turn_acc <= -TURN_LIMIT)
			turn_acc = TURN_LIMIT - 1;
		pos = turn_acc * ENCODER_RANGE + int'(now_v);

		r.speed = speed;
		r.turns = turn_acc[5:0];
		r.position = pos[18:0];
		r.command = '0;
		r.reversed = 1'b0;
		if (enable_v) begin
			if (stall_ticks < shadow_cfg.jam_ticks) begin
				r.command = target_v;
			end else begin
				r.command = (target_v == S32_MIN) ? S32_MAX : -target_v;
				r.reversed = 1'b1;
			end
			mag = (speed < 0) ? -longint'(speed) : longint'(speed);
			if (mag < longint'(shadow_cfg.jam_speed_threshold)
					&& stall_ticks < shadow_cfg.jam_ticks) begin
				stall_ticks++;
				reverse_done = '0;
			end else if (stall_ticks == shadow_cfg.jam_ticks
					&& reverse_done < shadow_cfg.reverse_ticks) begin
				reverse_done++;
			end else begin
				stall_ticks = '0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (errors < 100)
			$display("%t mismatch on result %0d, %s: got %0d, expected %0d", $realtime,
				checked, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		feedback_t got;
		feedback_t want;

		if (!arst_n) begin
			shadow_cfg.rpm_scale = 24'd48803;
			shadow_cfg.jam_speed_threshold = 31'd65536;
			shadow_cfg.jam_ticks = 16'd700;
			shadow_cfg.reverse_ticks = 16'd500;
			prior_speed = '0;
			last_speed = '0;
			turn_acc = 0;
			stall_ticks = '0;
			reverse_done = '0;
			expected_feedback_q.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RPM_SCALE:     shadow_cfg.rpm_scale = cfg_data[23:0];
					REG_JAM_THRESHOLD: shadow_cfg.jam_speed_threshold = cfg_data[30:0];
					REG_JAM_TICKS:     shadow_cfg.jam_ticks = cfg_data[15:0];
					REG_REVERSE_TICKS: shadow_cfg.reverse_ticks = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_feedback_q.push_back(compute_feedback(encoder_now, encoder_before,
					motor_rpm, target_speed, antijam_enable));
			if (out_valid && !out_stall) begin
				got.speed = filtered_speed;
				got.turns = turn_count;
				got.position = multiturn_position;
				got.command = speed_command;
				got.reversed = reversing;
				if (expected_feedback_q.size() == 0) begin
					report_mismatch("unexpected item", got.speed, '0);
				end else begin
					want = expected_feedback_q.pop_front();
					if (got.speed !== want.speed)
						report_mismatch("filtered_speed", got.speed, want.speed);
					if (got.turns !== want.turns)
						report_mismatch("turn_count", 32'(got.turns), 32'(want.turns));
					if (got.position !== want.position)
						report_mismatch("multiturn_position", 32'(got.position),
							32'(want.position));
					if (got.command !== want.command)
						report_mismatch("speed_command", got.command, want.command);
					if (got.reversed !== want.reversed)
						report_mismatch("reversing", 32'(got.reversed), 32'(want.reversed));
				end
				checked++;
			end
			pending <= expected_feedback_q.size();
		end
	end

endmodule

// ===== sim/tb_trigger_motor_feedback_antijam_top.sv =====
module tb_trigger_motor_feedback_antijam_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tmfa_pkg::*;

	localparam int ENCODER_RANGE   = 8191;
	localparam int TURN_LIMIT      = 18;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES    = 24;
	localparam int LONG_HOLD       = 80;
	localparam int CYCLE_LIMIT     = 600000;

	typedef enum logic [1:0] {
		IDLE_RECV_HEAVY,
		IDLE_SEND_HEAVY,
		IDLE_NONE
	} idle_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [12:0]        encoder_now;
	logic [12:0]        encoder_before;
	logic signed [15:0] motor_rpm;
	logic signed [31:0] target_speed;
	logic               antijam_enable;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] filtered_speed;
	logic signed [5:0]  turn_count;
	logic signed [18:0] multiturn_position;
	logic signed [31:0] speed_command;
	logic               reversing;

	int         pending;
	int         errors;
	int         checked;
	int         cycle_count = 0;
	int         items_sent = 0;
	int         settings_used = 0;
	idle_mode_t idle_mode = IDLE_RECV_HEAVY;
	bit         long_hold_done = 1'b0;

	always #5 clk = ~clk;

	trigger_motor_feedback_antijam_top #(
		.ENCODER_RANGE(ENCODER_RANGE),
		.TURN_LIMIT   (TURN_LIMIT)
	) i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.encoder_now       (encoder_now),
		.encoder_before    (encoder_before),
		.motor_rpm         (motor_rpm),
		.target_speed      (target_speed),
		.antijam_enable    (antijam_enable),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_speed    (filtered_speed),
		.turn_count        (turn_count),
		.multiturn_position(multiturn_position),
		.speed_command     (speed_command),
		.reversing         (reversing)
	);

	trigger_motor_feedback_antijam_checker #(
		.ENCODER_RANGE(ENCODER_RANGE),
		.TURN_LIMIT   (TURN_LIMIT)
	) i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.encoder_now       (encoder_now),
		.encoder_before    (encoder_before),
		.motor_rpm         (motor_rpm),
		.target_speed      (target_speed),
		.antijam_enable    (antijam_enable),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_speed    (filtered_speed),
		.turn_count        (turn_count),
		.multiturn_position(multiturn_position),
		.speed_command     (speed_command),
		.reversing         (reversing),
		.pending           (pending),
		.errors            (errors),
		.checked           (checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall, one long hold-off once idling stops
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_mode == IDLE_NONE && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_mode == IDLE_RECV_HEAVY) begin
				out_stall <= ($urandom_range(99) < 72);
			end else if (idle_mode == IDLE_SEND_HEAVY) begin
				out_stall <= ($urandom_range(99) < 32);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [12:0] now_v, input logic [12:0] before_v,
			input logic signed [15:0] rpm_v, input logic signed [31:0] target_v,
			input logic enable_v);
		int idle_pct;

		idle_pct = (idle_mode == IDLE_RECV_HEAVY) ? 32 : (idle_mode == IDLE_SEND_HEAVY) ? 72 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		encoder_now <= now_v;
		encoder_before <= before_v;
		motor_rpm <= rpm_v;
		target_speed <= target_v;
		antijam_enable <= enable_v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// upper data bits beyond each register's width are junk and must be dropped
	task automatic write_regs(input logic [23:0] scale, input logic [30:0] threshold,
			input logic [15:0] jam, input logic [15:0] rev);
		logic [31:0] junk;

		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= REG_RPM_SCALE;
		cfg_data <= {junk[6:0], scale};
		@(posedge clk);
		cfg_index <= REG_JAM_THRESHOLD;
		cfg_data <= threshold;
		@(posedge clk);
		cfg_index <= REG_JAM_TICKS;
		cfg_data <= {junk[30:16], jam};
		@(posedge clk);
		cfg_index <= REG_REVERSE_TICKS;
		cfg_data <= {junk[22:8], rev};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [12:0]        enc_last;
		logic [12:0]        now_v;
		logic [12:0]        before_v;
		logic signed [15:0] rpm_v;
		logic signed [31:0] target_v;
		logic               enable_v;
		logic [23:0]        scale;
		logic [30:0]        threshold;
		logic [15:0]        jam;
		logic [15:0]        rev;
		int                 run_left;
		int                 run_step;
		int                 run_rpm;
		bit                 run_slow;
		int                 mag;
		int                 idx;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RPM_SCALE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		encoder_now <= '0;
		encoder_before <= '0;
		motor_rpm <= '0;
		target_speed <= '0;
		antijam_enable <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and half-turn boundaries with reset register values
		send_item(13'd0, 13'd0, 16'sd0, 32'sd0, 1'b0);
		send_item(13'd8191, 13'd0, 16'sd32767, S32_MAX, 1'b1);
		send_item(13'd0, 13'd8191, -16'sd32768, S32_MIN, 1'b1);
		send_item(13'd4096, 13'd0, 16'sd32767, 32'sd1, 1'b1);
		send_item(13'd0, 13'd4096, 16'sd32767, -32'sd1, 1'b1);
		send_item(13'd4097, 13'd0, -16'sd32768, 32'sd65536, 1'b1);
		send_item(13'd0, 13'd4097, -16'sd32768, -32'sd65536, 1'b1);
		send_item(13'd8191, 13'd8191, -16'sd1, -32'sd1, 1'b1);
		send_item(13'h0AAA, 13'h1555, 16'h5555, 32'h5555_5555, 1'b0);
		send_item(13'h1555, 13'h0AAA, 16'hAAAA, 32'hAAAA_AAAA, 1'b1);
		send_item(13'd100, 13'd8000, 16'sd0, 32'sd12345, 1'b1);
		send_item(13'd8000, 13'd100, 16'sd0, S32_MIN, 1'b0);
		drain();

		// jam ticks zero: command reverses at once, most negative target saturates
		write_regs(24'd48803, 31'h7FFF_FFFF, 16'd0, 16'd0);
		send_item(13'd10, 13'd10, 16'sd0, S32_MIN, 1'b1);
		send_item(13'd10, 13'd10, 16'sd0, S32_MAX, 1'b1);
		send_item(13'd10, 13'd10, 16'sd0, 32'sd5, 1'b0);
		send_item(13'd10, 13'd10, 16'sd0, -32'sd7, 1'b1);
		drain();

		// short stall and reverse counts to walk the jam cycle
		write_regs(24'hFF_FFFF, 31'd65536, 16'd2, 16'd2);
		for (idx = 0; idx < 8; idx++)
			send_item(13'd20, 13'd20, 16'sd0, 32'sd1000 + idx, 1'b1);
		send_item(13'd20, 13'd20, 16'sd32767, S32_MIN, 1'b1);
		drain();

		enc_last = '0;
		run_left = 0;
		run_step = 0;
		run_rpm = 0;
		run_slow = 1'b0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					scale = 24'd48803; threshold = 31'd65536; jam = 16'd3; rev = 16'd5;
				end
				1: begin
					scale = 24'hFF_FFFF; threshold = 31'h7FFF_FFFF; jam = 16'd0; rev = 16'd0;
				end
				2: begin
					scale = 24'd0; threshold = 31'd0; jam = 16'hFFFF; rev = 16'hFFFF;
				end
				3: begin
					scale = 24'd0; threshold = 31'd1; jam = 16'd1; rev = 16'hFFFF;
				end
				default: begin
					scale = 24'($urandom_range(24'h1F_FFFF, 24'd1000));
					threshold = 31'($urandom_range(31'h40_0000, 31'h4000));
					jam = 16'($urandom_range(24, 1));
					rev = 16'($urandom_range(24, 0));
				end
			endcase
			write_regs(scale, threshold, jam, rev);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				idx = phase * ITEMS_PER_PHASE + k;
				if (idx < PHASES * ITEMS_PER_PHASE / 3)
					idle_mode = IDLE_RECV_HEAVY;
				else if (idx < 2 * PHASES * ITEMS_PER_PHASE / 3)
					idle_mode = IDLE_SEND_HEAVY;
				else
					idle_mode = IDLE_NONE;

				// runs of coherent motor feedback: slow ones to jam, fast ones to wrap turns
				if (run_left == 0) begin
					run_left = $urandom_range(120, 4);
					run_slow = ($urandom_range(99) < 45);
					mag = run_slow ? $urandom_range(40) : $urandom_range(4000, 1200);
					run_step = $urandom_range(1) ? mag : -mag;
					run_rpm = run_slow ? $urandom_range(300) : $urandom_range(9000, 800);
					if (run_step < 0)
						run_rpm = -run_rpm;
				end
				run_left--;
				if ($urandom_range(99) < 20) begin
					now_v = 13'($urandom);
					before_v = 13'($urandom);
					rpm_v = 16'($urandom);
					target_v = $urandom;
					enable_v = 1'($urandom);
				end else begin
					before_v = ($urandom_range(99) < 3) ? 13'($urandom) : enc_last;
					now_v = before_v + run_step[12:0];
					mag = run_rpm + $urandom_range(60) - 30;
					rpm_v = mag[15:0];
					case ($urandom_range(19))
						0: target_v = S32_MIN;
						1: target_v = S32_MAX;
						2: target_v = '0;
						default: target_v = $urandom;
					endcase
					enable_v = ($urandom_range(99) < 88);
				end
				enc_last = now_v;
				send_item(now_v, before_v, rpm_v, target_v, enable_v);
			end
			drain();
		end

		$display("covered %0d items under %0d register settings, %0d results compared",
			items_sent, settings_used, checked);
		$display("idle patterns: receiver-heavy, sender-heavy, none with a %0d-cycle hold-off",
			LONG_HOLD);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
